// ----- rtl/mdfm_pkg.sv -----
// Shared types and constants for the motor drive fault monitor.
// No dependencies; every other file of the block imports this package.

package mdfm_pkg;

	localparam int CNT_W  = 8;
	localparam int NTRIPS = 7;

	// Qualifier trip counts and immediate temperature limits.
	localparam logic [CNT_W-1:0] PHASE_TRIP_COUNT = 8'd10;
	localparam logic [CNT_W-1:0] DQ_TRIP_COUNT    = 8'd10;
	localparam logic [CNT_W-1:0] OVER_TRIP_COUNT  = 8'd10;
	localparam logic [CNT_W-1:0] UNDER_TRIP_COUNT = 8'd10;
	localparam logic signed [15:0] MOTOR_HOT_LIMIT = 16'sd1200;
	localparam logic signed [15:0] DRIVE_HOT_LIMIT = 16'sd900;

	// Configuration register indexes.
	localparam logic [2:0] REG_PHASE_LIMIT = 3'd0;
	localparam logic [2:0] REG_D_UPPER     = 3'd1;
	localparam logic [2:0] REG_D_LOWER     = 3'd2;
	localparam logic [2:0] REG_Q_UPPER     = 3'd3;
	localparam logic [2:0] REG_Q_LOWER     = 3'd4;
	localparam logic [2:0] REG_BUS_OVER    = 3'd5;
	localparam logic [2:0] REG_BUS_UNDER   = 3'd6;
	localparam logic [2:0] REG_AUX_UNDER   = 3'd7;

	// Bit positions in the trip vectors.
	localparam int TRIP_PHASE     = 0;
	localparam int TRIP_DQ        = 1;
	localparam int TRIP_BUS_OVER  = 2;
	localparam int TRIP_BUS_UNDER = 3;
	localparam int TRIP_AUX       = 4;
	localparam int TRIP_MOT_TEMP  = 5;
	localparam int TRIP_CTL_TEMP  = 6;

	// Fault codes reported for the last tripped check.
	localparam logic [2:0] CODE_NONE      = 3'd0;
	localparam logic [2:0] CODE_PHASE     = 3'd1;
	localparam logic [2:0] CODE_DQ        = 3'd2;
	localparam logic [2:0] CODE_BUS_OVER  = 3'd3;
	localparam logic [2:0] CODE_BUS_UNDER = 3'd4;
	localparam logic [2:0] CODE_AUX       = 3'd5;
	localparam logic [2:0] CODE_MOT_TEMP  = 3'd6;
	localparam logic [2:0] CODE_CTL_TEMP  = 3'd7;

	typedef struct packed {
		logic        [14:0] phase_current_limit;
		logic signed [15:0] d_current_upper;
		logic signed [15:0] d_current_lower;
		logic signed [15:0] q_current_upper;
		logic signed [15:0] q_current_lower;
		logic        [15:0] bus_over_limit;
		logic        [15:0] bus_under_limit;
		logic        [15:0] aux_under_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] phase_a_current;
		logic signed [15:0] phase_b_current;
		logic signed [15:0] phase_c_current;
		logic signed [15:0] d_current;
		logic signed [15:0] q_current;
		logic        [15:0] bus_voltage;
		logic        [15:0] aux_voltage;
		logic               motor_running;
		logic signed [15:0] motor_temperature;
		logic signed [15:0] controller_temperature;
	} in_item_t;

	typedef struct packed {
		logic [NTRIPS-1:0] trips_now;
		logic [NTRIPS-1:0] latched_fault_bits;
		logic [2:0]        fault_code;
		logic              controller_fault;
	} out_item_t;

	// Raw per-sample violations, before qualification.
	typedef struct packed {
		logic phase;
		logic dq;
		logic bus_over;
		logic bus_under;
		logic aux;
		logic mot_hot;
		logic ctl_hot;
	} viol_t;

endpackage

// ----- rtl/mdfm_if.sv -----
// Valid/ready channel interfaces for the sample and result streams.
// Depends on mdfm_pkg for the payload types.

interface mdfm_in_if;
	import mdfm_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mdfm_out_if;
	import mdfm_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/mdfm_cfg_regs.sv -----
// Configuration register file of the fault monitor: write-only, one register per index.
// Depends on mdfm_pkg.

module mdfm_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_wr_data,
	output mdfm_pkg::cfg_t    cfg
);
	import mdfm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_current_limit <= 15'h7FFF;
			cfg_q.d_current_upper     <= 16'sh7FFF;
			cfg_q.d_current_lower     <= 16'sh8000;
			cfg_q.q_current_upper     <= 16'sh7FFF;
			cfg_q.q_current_lower     <= 16'sh8000;
			cfg_q.bus_over_limit      <= 16'hFFFF;
			cfg_q.bus_under_limit     <= 16'h0000;
			cfg_q.aux_under_limit     <= 16'h0000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PHASE_LIMIT: cfg_q.phase_current_limit <= cfg_wr_data[14:0];
				REG_D_UPPER:     cfg_q.d_current_upper     <= cfg_wr_data;
				REG_D_LOWER:     cfg_q.d_current_lower     <= cfg_wr_data;
				REG_Q_UPPER:     cfg_q.q_current_upper     <= cfg_wr_data;
				REG_Q_LOWER:     cfg_q.q_current_lower     <= cfg_wr_data;
				REG_BUS_OVER:    cfg_q.bus_over_limit      <= cfg_wr_data;
				REG_BUS_UNDER:   cfg_q.bus_under_limit     <= cfg_wr_data;
				REG_AUX_UNDER:   cfg_q.aux_under_limit     <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/mdfm_checks.sv -----
// Threshold comparators: turns one registered sample into raw violation flags.
// Depends on mdfm_pkg.

module mdfm_checks (
	input  mdfm_pkg::in_item_t item,
	input  mdfm_pkg::cfg_t     cfg,
	output mdfm_pkg::viol_t    viol
);
	import mdfm_pkg::*;

	logic signed [16:0] lim_pos;
	logic signed [16:0] lim_neg;
	logic signed [16:0] ia;
	logic signed [16:0] ib;
	logic signed [16:0] ic;
	logic               phase_hi;
	logic               phase_lo;

	// The phase limit is symmetric; 17 bits hold both +limit and -limit safely.
	assign lim_pos = $signed({2'b00, cfg.phase_current_limit});
	assign lim_neg = -lim_pos;
	assign ia = $signed({item.phase_a_current[15], item.phase_a_current});
	assign ib = $signed({item.phase_b_current[15], item.phase_b_current});
	assign ic = $signed({item.phase_c_current[15], item.phase_c_current});

	assign phase_hi = (ia > lim_pos) || (ib > lim_pos) || (ic > lim_pos);
	assign phase_lo = (ia < lim_neg) || (ib < lim_neg) || (ic < lim_neg);

	always_comb begin
		viol.phase     = phase_hi || phase_lo;
		viol.dq        = ($signed(item.d_current) > $signed(cfg.d_current_upper)) ||
		                 ($signed(item.d_current) < $signed(cfg.d_current_lower)) ||
		                 ($signed(item.q_current) < $signed(cfg.q_current_lower)) ||
		                 ($signed(item.q_current) > $signed(cfg.q_current_upper));
		viol.bus_over  = item.bus_voltage >= cfg.bus_over_limit;
		viol.bus_under = item.bus_voltage <= cfg.bus_under_limit;
		viol.aux       = (item.aux_voltage <= cfg.aux_under_limit) && item.motor_running;
		viol.mot_hot   = $signed(item.motor_temperature) >= MOTOR_HOT_LIMIT;
		viol.ctl_hot   = $signed(item.controller_temperature) >= DRIVE_HOT_LIMIT;
	end

endmodule

// ----- rtl/mdfm_qualifier.sv -----
// Up/down fault qualifier: counts violations up, clean samples down, trips at its count.
// Depends on mdfm_pkg for the counter width.

module mdfm_qualifier (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       bad,
	input  logic [mdfm_pkg::CNT_W-1:0] trip_count,
	output logic                       trip
);
	import mdfm_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] count_next;

	// The count never passes trip_count - 1, so the increment cannot wrap.
	assign count_inc = count_q + {{(CNT_W-1){1'b0}}, 1'b1};
	assign trip      = en && bad && (count_inc >= trip_count);

	always_comb begin
		count_next = count_q;
		if (en) begin
			if (bad) begin
				count_next = trip ? '0 : count_inc;
			end else if (count_q != '0) begin
				count_next = count_q - {{(CNT_W-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	a_count_below_trip: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < trip_count)
		else $error("qualifier count reached its trip count without clearing");

	a_trip_clears: assert property (@(posedge clk) disable iff (!arst_n)
		trip |=> count_q == '0)
		else $error("qualifier count not cleared after a trip");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(count_q))
		else $error("qualifier count moved without a sample");

endmodule

// ----- rtl/motor_drive_fault_monitor_unit.sv -----
// Top level of the motor drive fault monitor: input register, checks, qualifiers, result register.
// Depends on mdfm_pkg, mdfm_if, mdfm_cfg_regs, mdfm_checks and mdfm_qualifier.
//
// Usage: one sample set per control tick arrives on the sample channel (valid/ready);
// one result per sample leaves on the result channel with this tick's trip flags, the
// sticky latched faults, the code of the last tripped check and a sticky fault flag.
// Thresholds are set through the write-only configuration port while no request is
// in flight.
// Flow: an accepted request is held in the input register, evaluated there and written
// to the result register once that register can advance, from where the receiver takes it.
// Throughput: one request per cycle while result.ready stays high; the single pass of
// comparators and 8-bit counters between input and result register sets this figure.
// Stall: while the receiver holds ready low the result register keeps its contents
// and the input register can still take one further request, after which sample.ready
// falls until the result is taken.
// Reset: asserting arst_n clears the counters, sticky faults, fault code, pending
// requests and restores every threshold to its default.

module motor_drive_fault_monitor_unit (
	input  logic              clk,
	input  logic              arst_n,
	mdfm_in_if.sink           sample,
	mdfm_out_if.source        result,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_wr_data
);
	import mdfm_pkg::*;

	cfg_t              cfg;
	viol_t             viol;
	in_item_t          item_s1;
	logic              valid_s1;
	out_item_t         res_s2;
	logic              res_valid_s2;
	logic [NTRIPS-1:0] sticky_q;
	logic [2:0]        code_q;
	logic              seen_q;

	logic              advance;
	logic              fire;
	logic              phase_trip;
	logic              dq_trip;
	logic              over_trip;
	logic              under_trip;
	logic [NTRIPS-1:0] trips;
	logic [NTRIPS-1:0] sticky_next;
	logic [2:0]        code_next;
	logic              seen_next;

	assign advance      = !res_valid_s2 || result.ready;
	assign fire         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	mdfm_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	mdfm_checks u_checks (
		.item (item_s1),
		.cfg  (cfg),
		.viol (viol)
	);

	mdfm_qualifier u_phase_qual (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire),
		.bad        (viol.phase),
		.trip_count (PHASE_TRIP_COUNT),
		.trip       (phase_trip)
	);

	mdfm_qualifier u_dq_qual (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire),
		.bad        (viol.dq),
		.trip_count (DQ_TRIP_COUNT),
		.trip       (dq_trip)
	);

	mdfm_qualifier u_over_qual (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire),
		.bad        (viol.bus_over),
		.trip_count (OVER_TRIP_COUNT),
		.trip       (over_trip)
	);

	// An overvoltage trip takes the tick: the undervoltage counter is frozen then.
	mdfm_qualifier u_under_qual (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire && !over_trip),
		.bad        (viol.bus_under),
		.trip_count (UNDER_TRIP_COUNT),
		.trip       (under_trip)
	);

	always_comb begin
		trips                 = '0;
		trips[TRIP_PHASE]     = phase_trip;
		trips[TRIP_DQ]        = dq_trip;
		trips[TRIP_BUS_OVER]  = over_trip;
		trips[TRIP_BUS_UNDER] = under_trip;
		trips[TRIP_AUX]       = viol.aux;
		trips[TRIP_MOT_TEMP]  = viol.mot_hot;
		trips[TRIP_CTL_TEMP]  = viol.ctl_hot;

		// Later checks override earlier ones when several trip together.
		code_next = code_q;
		if (trips[TRIP_PHASE])     code_next = CODE_PHASE;
		if (trips[TRIP_DQ])        code_next = CODE_DQ;
		if (trips[TRIP_BUS_OVER])  code_next = CODE_BUS_OVER;
		if (trips[TRIP_BUS_UNDER]) code_next = CODE_BUS_UNDER;
		if (trips[TRIP_AUX])       code_next = CODE_AUX;
		if (trips[TRIP_MOT_TEMP])  code_next = CODE_MOT_TEMP;
		if (trips[TRIP_CTL_TEMP])  code_next = CODE_CTL_TEMP;

		sticky_next = sticky_q | trips;
		seen_next   = seen_q || (trips != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			sticky_q     <= '0;
			code_q       <= CODE_NONE;
			seen_q       <= 1'b0;
		end else begin
			if (sample.valid && sample.ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				res_valid_s2 <= 1'b1;
				sticky_q     <= sticky_next;
				code_q       <= code_next;
				seen_q       <= seen_next;
			end else if (result.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1 <= sample.data;
		end
		if (fire) begin
			res_s2.trips_now          <= trips;
			res_s2.latched_fault_bits <= sticky_next;
			res_s2.fault_code         <= code_next;
			res_s2.controller_fault   <= seen_next;
		end
	end

	assign result.valid = res_valid_s2;
	assign result.data  = res_s2;

	a_seen_matches_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> (res_s2.controller_fault == (res_s2.latched_fault_bits != '0)))
		else $error("controller fault flag disagrees with latched faults");

	a_bus_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> !(res_s2.trips_now[TRIP_BUS_OVER] &&
		                   res_s2.trips_now[TRIP_BUS_UNDER]))
		else $error("bus over and under tripped in the same tick");

	a_code_tracks_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(code_q == CODE_NONE) == !seen_q)
		else $error("fault code and fault flag out of step");

	a_fire_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid_s2)
		else $error("evaluated request did not reach the result register");

endmodule
